>>> rtl/vna_pkg.sv
// shared constants, types and helpers of the vertex normal accumulator
// used by vna_unit and vertex_normal_accumulator; no dependencies
`default_nettype none

package vna_pkg;

  localparam int VERTEX_COUNT = 1024;              // power of two, 4 to 65536
  localparam int VTX_AW       = $clog2(VERTEX_COUNT);
  localparam int IDX_W        = 10;
  localparam int POS_W        = 32;
  localparam int NRM_W        = 16;
  localparam int EDGE_W       = POS_W + 1;
  localparam int VEC_W        = 50;                // cross product range
  localparam int SQ_W         = 63;                // sum of squares and root
  localparam int LEN_W        = 32;
  localparam int MAG_W        = 30;                // magnitude after unit fit
  localparam int Q_W          = 15;                // quotient bits, max 16384
  localparam int ONE_SH       = 14;                // q1.14 one
  localparam int EDGE_FIT_K   = 24;
  localparam int UNIT_FIT_K   = 30;

  typedef logic [1:0] req_t;
  localparam req_t REQ_LOAD = 2'd0;
  localparam req_t REQ_PUSH = 2'd1;
  localparam req_t REQ_READ = 2'd2;
  localparam req_t REQ_NONE = 2'd3;                // undefined code, ignored

  typedef enum logic [1:0] {FIT_KEEP, FIT_HALVE, FIT_DOUBLE} fit_op_t;

  typedef logic [VTX_AW-1:0] vaddr_t;

  // packed with x in the low bits, same layout as the normal memory word
  typedef struct packed {
    logic signed [NRM_W-1:0] z;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] x;
  } nvec_t;

  typedef struct packed {
    logic                    start;
    logic signed [VEC_W-1:0] z;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] x;
  } unit_req_t;

  typedef struct packed {
    logic  done;
    nvec_t n;
  } unit_rsp_t;

  function automatic logic [VEC_W-1:0] vmag(input logic signed [VEC_W-1:0] v);
    return v[VEC_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [VEC_W-1:0] max3(input logic [VEC_W-1:0] a,
                                            input logic [VEC_W-1:0] b,
                                            input logic [VEC_W-1:0] c);
    logic [VEC_W-1:0] m;
    m = (b > a) ? b : a;
    return (c > m) ? c : m;
  endfunction

  // one step of block scaling toward [2^(k-1), 2^k)
  function automatic fit_op_t fit_op(input logic [VEC_W-1:0] m, input int k);
    logic [VEC_W-1:0] lim;
    lim = VEC_W'(1) << k;
    if (m == '0) return FIT_KEEP;
    if (m >= lim) return FIT_HALVE;
    if (m < (lim >> 1)) return FIT_DOUBLE;
    return FIT_KEEP;
  endfunction

  function automatic vaddr_t vtx_addr(input logic [IDX_W-1:0] i);
    return VTX_AW'(i % VERTEX_COUNT);
  endfunction

endpackage

`default_nettype wire

>>> rtl/vna_unit.sv
// vector normalizer: block scaling, sum of squares, bit-pair square root
// and restoring division to q1.14; uses vna_pkg
`default_nettype none

module vna_unit
  import vna_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire unit_req_t req,
  output unit_rsp_t      rsp
);

  typedef enum logic [5:0] {
    U_IDLE = 6'b000001,
    U_FIT  = 6'b000010,
    U_SQ   = 6'b000100,
    U_ROOT = 6'b001000,
    U_DSET = 6'b010000,
    U_DIV  = 6'b100000
  } ustate_t;

  ustate_t                 state;
  logic signed [VEC_W-1:0] vx, vy, vz;
  logic [1:0]              sq_cnt;
  logic [1:0]              comp;
  logic [3:0]              dcnt;
  logic [SQ_W-1:0]         rad;
  logic [SQ_W-1:0]         root;
  logic [SQ_W-1:0]         bitr;
  logic [LEN_W-1:0]        rem;
  logic [Q_W-1:0]          nsh;
  logic [Q_W-1:0]          q;
  nvec_t                   res;
  logic                    done;

  logic [VEC_W-1:0]        mx, my, mz;
  fit_op_t                 op;
  logic signed [VEC_W-1:0] vsel;
  logic [MAG_W-1:0]        msel;
  logic [MAG_W-1:0]        sqm;
  logic [2*MAG_W-1:0]      sq;
  logic [LEN_W-1:0]        len;
  logic [SQ_W-1:0]         trial;
  logic [MAG_W+Q_W-1:0]    numer;
  logic [LEN_W:0]          t;
  logic                    ge;
  logic [Q_W-1:0]          qn;
  logic signed [NRM_W-1:0] qs;

  always_comb begin
    mx = vmag(vx);
    my = vmag(vy);
    mz = vmag(vz);
    op = fit_op(max3(mx, my, mz), UNIT_FIT_K);
    case (sq_cnt)
      2'd0:    sqm = mx[MAG_W-1:0];
      2'd1:    sqm = my[MAG_W-1:0];
      default: sqm = mz[MAG_W-1:0];
    endcase
    sq = sqm * sqm;
    case (comp)
      2'd0: begin
        vsel = vx;
        msel = mx[MAG_W-1:0];
      end
      2'd1: begin
        vsel = vy;
        msel = my[MAG_W-1:0];
      end
      default: begin
        vsel = vz;
        msel = mz[MAG_W-1:0];
      end
    endcase
    len   = root[LEN_W-1:0];
    trial = root + bitr;
    numer = {msel, {ONE_SH{1'b0}}} + (MAG_W+Q_W)'(len >> 1);
    t     = {rem, nsh[Q_W-1]};
    ge    = t >= {1'b0, len};
    qn    = {q[Q_W-2:0], ge};
    qs    = vsel[VEC_W-1] ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (req.start) begin
            vx    <= req.x;
            vy    <= req.y;
            vz    <= req.z;
            state <= U_FIT;
          end
        end
        U_FIT: begin
          case (op)
            FIT_HALVE: begin
              vx <= vx >>> 1;
              vy <= vy >>> 1;
              vz <= vz >>> 1;
            end
            FIT_DOUBLE: begin
              vx <= vx <<< 1;
              vy <= vy <<< 1;
              vz <= vz <<< 1;
            end
            default: begin
              sq_cnt <= 2'd0;
              rad    <= '0;
              state  <= U_SQ;
            end
          endcase
        end
        U_SQ: begin
          rad    <= rad + SQ_W'(sq);
          sq_cnt <= sq_cnt + 2'd1;
          if (sq_cnt == 2'd2) begin
            root  <= '0;
            bitr  <= SQ_W'(1) << (SQ_W - 1);
            state <= U_ROOT;
          end
        end
        U_ROOT: begin
          if (rad >= trial) begin
            rad  <= rad - trial;
            root <= (root >> 1) + bitr;
          end else begin
            root <= root >> 1;
          end
          bitr <= bitr >> 2;
          if (bitr[0]) begin
            comp  <= 2'd0;
            state <= U_DSET;
          end
        end
        U_DSET: begin
          if (len == '0) begin
            res   <= '0;
            done  <= 1'b1;
            state <= U_IDLE;
          end else begin
            rem   <= LEN_W'(numer[MAG_W+Q_W-1:Q_W]);
            nsh   <= numer[Q_W-1:0];
            q     <= '0;
            dcnt  <= '0;
            state <= U_DIV;
          end
        end
        U_DIV: begin
          rem  <= ge ? LEN_W'(t - {1'b0, len}) : t[LEN_W-1:0];
          nsh  <= nsh << 1;
          q    <= qn;
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'(Q_W - 1)) begin
            case (comp)
              2'd0:    res.x <= qs;
              2'd1:    res.y <= qs;
              default: res.z <= qs;
            endcase
            comp <= comp + 2'd1;
            if (comp == 2'd2) begin
              done  <= 1'b1;
              state <= U_IDLE;
            end else begin
              state <= U_DSET;
            end
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.n    = res;

endmodule

`default_nettype wire

>>> rtl/vertex_normal_accumulator.sv
// top level: position and normal memories, triangle window, edge and cross
// product datapath, and the read-modify-write sequencer; uses vna_pkg, vna_unit
`default_nettype none

// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tuser: req_type; tdata: vertex_index,
//                                          pos_x, pos_y, pos_z
// m_axis    out  m_axis_tvalid/tready      tdata: normal_x, normal_y, normal_z
// cfg       in   cfg_wr_en (no wait)       cfg_wr_data: topology_mode
//
// a load or a push that does not close a triangle keeps the input ready; a read
// passes ST_READ, then waits in ST_RSEND for the output register to empty
// a push that closes a triangle runs edge scaling, six multiply-accumulates,
// then four passes through the shared normalizer (scaling, 3 squares, 32 root
// steps and 3 restoring divisions)
// reset starts a clearing pass over every entry of the normal memory; no beat is
// accepted meanwhile, configuration writes are taken at any time
// the output register lets a result wait while the next beat is accepted

module vertex_normal_accumulator
  import vna_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [111:0] s_axis_tdata,  // vertex_index, pos_x, pos_y, pos_z, zero fill
  input  wire logic [1:0]   s_axis_tuser,  // req_type
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [47:0]       m_axis_tdata,  // normal_x, normal_y, normal_z
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_wr_data    // topology_mode
);

  typedef enum logic [14:0] {
    ST_CLR    = 15'b000000000000001,
    ST_IDLE   = 15'b000000000000010,
    ST_READ   = 15'b000000000000100,
    ST_RSEND  = 15'b000000000001000,
    ST_PA     = 15'b000000000010000,
    ST_PB     = 15'b000000000100000,
    ST_PC     = 15'b000000001000000,
    ST_PD     = 15'b000000010000000,
    ST_FIT    = 15'b000000100000000,
    ST_CROSS  = 15'b000001000000000,
    ST_FSTART = 15'b000010000000000,
    ST_FACE   = 15'b000100000000000,
    ST_NRD    = 15'b001000000000000,
    ST_NSUM   = 15'b010000000000000,
    ST_NWAIT  = 15'b100000000000000
  } state_t;

  state_t state;

  // input beat fields
  logic [IDX_W-1:0] vertex_index;
  logic [POS_W-1:0] pos_x, pos_y, pos_z;
  req_t             req_type;
  logic             in_acc;
  vaddr_t           in_addr;

  assign vertex_index  = s_axis_tdata[9:0];
  assign pos_x         = s_axis_tdata[41:10];
  assign pos_y         = s_axis_tdata[73:42];
  assign pos_z         = s_axis_tdata[105:74];
  assign req_type      = s_axis_tuser;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_addr       = vtx_addr(vertex_index);

  // position memory {z, y, x} and normal memory {z, y, x}
  logic [3*POS_W-1:0] pos_mem [VERTEX_COUNT];
  logic [3*NRM_W-1:0] nrm_mem [VERTEX_COUNT];
  logic               pos_we, nrm_we;
  vaddr_t             pos_wa, pos_ra, nrm_wa, nrm_ra;
  logic [3*POS_W-1:0] pos_wd, pos_rd;
  logic [3*NRM_W-1:0] nrm_wd, nrm_rd;

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (nrm_we) nrm_mem[nrm_wa] <= nrm_wd;
    nrm_rd <= nrm_mem[nrm_ra];
  end

  // control and datapath registers
  logic                     mode;
  vaddr_t                   win_first, win_second;
  logic [1:0]               win_fill;
  vaddr_t                   ca, cb, cc;
  vaddr_t                   clr_cnt;
  logic [3*POS_W-1:0]       pa;
  logic signed [EDGE_W-1:0] e1 [3];
  logic signed [EDGE_W-1:0] e2 [3];
  logic signed [VEC_W-1:0]  cr [3];
  logic [2:0]               cross_cnt;
  logic [1:0]               corner;
  nvec_t                    face;
  logic [3*NRM_W-1:0]       rbuf;

  unit_req_t ureq;
  unit_rsp_t ursp;

  vna_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (ureq),
    .rsp (ursp)
  );

  // signed q16.16 difference b - a, one bit wider
  function automatic logic signed [EDGE_W-1:0] edge_diff(input logic [POS_W-1:0] b,
                                                         input logic [POS_W-1:0] a);
    return $signed({b[POS_W-1], b}) - $signed({a[POS_W-1], a});
  endfunction

  // edge scaling decisions
  fit_op_t op1, op2;
  always_comb begin
    op1 = fit_op(max3(vmag(VEC_W'(e1[0])), vmag(VEC_W'(e1[1])), vmag(VEC_W'(e1[2]))),
                 EDGE_FIT_K);
    op2 = fit_op(max3(vmag(VEC_W'(e2[0])), vmag(VEC_W'(e2[1])), vmag(VEC_W'(e2[2]))),
                 EDGE_FIT_K);
  end

  // cross product, one product per cycle: even steps add, odd steps subtract
  logic signed [EDGE_FIT_K:0] mul_a, mul_b;
  logic signed [VEC_W-1:0]    prod;
  always_comb begin
    case (cross_cnt)
      3'd0: begin
        mul_a = $signed(e1[1][EDGE_FIT_K:0]);
        mul_b = $signed(e2[2][EDGE_FIT_K:0]);
      end
      3'd1: begin
        mul_a = $signed(e1[2][EDGE_FIT_K:0]);
        mul_b = $signed(e2[1][EDGE_FIT_K:0]);
      end
      3'd2: begin
        mul_a = $signed(e1[2][EDGE_FIT_K:0]);
        mul_b = $signed(e2[0][EDGE_FIT_K:0]);
      end
      3'd3: begin
        mul_a = $signed(e1[0][EDGE_FIT_K:0]);
        mul_b = $signed(e2[2][EDGE_FIT_K:0]);
      end
      3'd4: begin
        mul_a = $signed(e1[0][EDGE_FIT_K:0]);
        mul_b = $signed(e2[1][EDGE_FIT_K:0]);
      end
      3'd5: begin
        mul_a = $signed(e1[1][EDGE_FIT_K:0]);
        mul_b = $signed(e2[0][EDGE_FIT_K:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // corner being updated and its summed normal
  vaddr_t                  corner_addr;
  logic signed [VEC_W-1:0] sum_x, sum_y, sum_z;
  always_comb begin
    case (corner)
      2'd0:    corner_addr = ca;
      2'd1:    corner_addr = cb;
      default: corner_addr = cc;
    endcase
    sum_x = VEC_W'($signed(nrm_rd[NRM_W-1:0])) + VEC_W'(face.x);
    sum_y = VEC_W'($signed(nrm_rd[2*NRM_W-1:NRM_W])) + VEC_W'(face.y);
    sum_z = VEC_W'($signed(nrm_rd[3*NRM_W-1:2*NRM_W])) + VEC_W'(face.z);
  end

  // normalizer request: face normal first, then each corner sum
  always_comb begin
    ureq.start = (state == ST_FSTART) || (state == ST_NSUM);
    if (state == ST_FSTART) begin
      ureq.x = cr[0];
      ureq.y = cr[1];
      ureq.z = cr[2];
    end else begin
      ureq.x = sum_x;
      ureq.y = sum_y;
      ureq.z = sum_z;
    end
  end

  // memory port steering
  always_comb begin
    pos_we = 1'b0;
    pos_wa = in_addr;
    pos_wd = {pos_z, pos_y, pos_x};
    nrm_we = 1'b0;
    nrm_wa = in_addr;
    nrm_wd = '0;
    nrm_ra = in_addr;
    case (state)
      ST_PB:   pos_ra = cb;
      ST_PC:   pos_ra = cc;
      default: pos_ra = ca;
    endcase
    case (state)
      ST_CLR: begin
        nrm_we = 1'b1;
        nrm_wa = clr_cnt;
      end
      ST_IDLE: begin
        // a load writes the position and clears the normal
        if (in_acc && req_type == REQ_LOAD) begin
          pos_we = 1'b1;
          nrm_we = 1'b1;
        end
      end
      ST_NRD: nrm_ra = corner_addr;
      ST_NWAIT: begin
        nrm_wa = corner_addr;
        nrm_wd = ursp.n;
        nrm_we = ursp.done;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLR;
      clr_cnt       <= '0;
      mode          <= 1'b0;
      win_first     <= '0;
      win_second    <= '0;
      win_fill      <= 2'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == vaddr_t'(VERTEX_COUNT - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc) begin
            case (req_type)
              REQ_LOAD: win_fill <= 2'd0;
              REQ_PUSH: begin
                case (win_fill)
                  2'd0: begin
                    win_first <= in_addr;
                    win_fill  <= 2'd1;
                  end
                  2'd1: begin
                    win_second <= in_addr;
                    win_fill   <= 2'd2;
                  end
                  default: begin
                    // window full: this index closes a triangle
                    ca    <= win_first;
                    cb    <= win_second;
                    cc    <= in_addr;
                    state <= ST_PA;
                    if (mode) begin
                      win_first  <= win_second;
                      win_second <= in_addr;
                    end else begin
                      win_fill <= 2'd0;
                    end
                  end
                endcase
              end
              REQ_READ: state <= ST_READ;
              default: ;  // unused request code is dropped
            endcase
          end
        end
        ST_READ: begin
          rbuf  <= nrm_rd;
          state <= ST_RSEND;
        end
        ST_RSEND: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= rbuf;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        ST_PA: state <= ST_PB;
        ST_PB: begin
          pa    <= pos_rd;
          state <= ST_PC;
        end
        ST_PC: begin
          e1[0] <= edge_diff(pos_rd[POS_W-1:0], pa[POS_W-1:0]);
          e1[1] <= edge_diff(pos_rd[2*POS_W-1:POS_W], pa[2*POS_W-1:POS_W]);
          e1[2] <= edge_diff(pos_rd[3*POS_W-1:2*POS_W], pa[3*POS_W-1:2*POS_W]);
          state <= ST_PD;
        end
        ST_PD: begin
          e2[0] <= edge_diff(pos_rd[POS_W-1:0], pa[POS_W-1:0]);
          e2[1] <= edge_diff(pos_rd[2*POS_W-1:POS_W], pa[2*POS_W-1:POS_W]);
          e2[2] <= edge_diff(pos_rd[3*POS_W-1:2*POS_W], pa[3*POS_W-1:2*POS_W]);
          state <= ST_FIT;
        end
        ST_FIT: begin
          // both edges scale one step per cycle until in range
          for (int i = 0; i < 3; i++) begin
            if (op1 == FIT_HALVE) e1[i] <= e1[i] >>> 1;
            else if (op1 == FIT_DOUBLE) e1[i] <= e1[i] <<< 1;
            if (op2 == FIT_HALVE) e2[i] <= e2[i] >>> 1;
            else if (op2 == FIT_DOUBLE) e2[i] <= e2[i] <<< 1;
          end
          if (op1 == FIT_KEEP && op2 == FIT_KEEP) begin
            cross_cnt <= 3'd0;
            cr[0]     <= '0;
            cr[1]     <= '0;
            cr[2]     <= '0;
            state     <= ST_CROSS;
          end
        end
        ST_CROSS: begin
          if (cross_cnt[0]) cr[cross_cnt[2:1]] <= cr[cross_cnt[2:1]] - prod;
          else cr[cross_cnt[2:1]] <= cr[cross_cnt[2:1]] + prod;
          cross_cnt <= cross_cnt + 3'd1;
          if (cross_cnt == 3'd5) state <= ST_FSTART;
        end
        ST_FSTART: state <= ST_FACE;
        ST_FACE: begin
          if (ursp.done) begin
            face   <= ursp.n;
            corner <= 2'd0;
            state  <= ST_NRD;
          end
        end
        ST_NRD:  state <= ST_NSUM;
        ST_NSUM: state <= ST_NWAIT;
        ST_NWAIT: begin
          // write-back lands before the next corner's read is issued
          if (ursp.done) begin
            corner <= corner + 2'd1;
            state  <= (corner == 2'd2) ? ST_IDLE : ST_NRD;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // a mode write also empties the triangle window
      if (cfg_wr_en) begin
        mode     <= cfg_wr_data;
        win_fill <= 2'd0;
      end
    end
  end

endmodule

`default_nettype wire
